/* rtl/core/gtp_pkg.sv */
`default_nettype none

package gtp_pkg;

  // Command codes carried in the input tuser
  localparam int CMD_BITS = 2;

  typedef enum logic [CMD_BITS-1:0] {
    CMD_START  = 2'd0,
    CMD_TEST   = 2'd1,
    CMD_ACCEPT = 2'd2,
    CMD_AGE    = 2'd3
  } cmd_t;

  // Decoded command, one flag per operation
  typedef struct packed {
    logic start;
    logic test;
    logic accept;
    logic age;
  } op_t;

  localparam int OP_BITS = $bits(op_t);

  // Fixed field widths
  localparam int TOL_BITS    = 12;
  localparam int AREA_BITS   = 24;
  localparam int PERIM_BITS  = 16;
  localparam int PRED_BITS   = 16;
  localparam int REPORT_BITS = 16;

  localparam logic [TOL_BITS-1:0] TOL_RESET = 12'd20;

  localparam int PRED_MAX = 32767;
  localparam int PRED_MIN = -32768;

  // Command queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = 2;

endpackage

`default_nettype wire

/* rtl/core/gtp_front.sv */
`default_nettype none

module gtp_front
  import gtp_pkg::*;
#(
  parameter int COORD_BITS = 12
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic s_axis_tvalid,
  output logic      s_axis_tready,
  // tuser: cmd
  input  wire logic [CMD_BITS-1:0] s_axis_tuser,
  // tdata: cx, cy, obj_area, obj_perimeter, bx, by, bh, bw, zero pad
  input  wire logic [((6*COORD_BITS+AREA_BITS+PERIM_BITS+7)/8)*8-1:0] s_axis_tdata,
  output logic      item_valid,
  input  wire logic item_ready,
  output op_t       item_op,
  output logic [6*COORD_BITS+AREA_BITS+PERIM_BITS-1:0] item_data
);

  localparam int IN_BITS = 6*COORD_BITS + AREA_BITS + PERIM_BITS;

  op_t op_dec;

  // Command decode
  always_comb begin
    op_dec = '0;
    unique case (cmd_t'(s_axis_tuser))
      CMD_START:  op_dec.start  = 1'b1;
      CMD_TEST:   op_dec.test   = 1'b1;
      CMD_ACCEPT: op_dec.accept = 1'b1;
      CMD_AGE:    op_dec.age    = 1'b1;
      default:    op_dec        = '0;
    endcase
  end

  // Input register, refilled when empty or whenever the queue takes its content
  assign s_axis_tready = !item_valid || item_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (s_axis_tready) begin
      item_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      item_op   <= op_dec;
      item_data <= s_axis_tdata[IN_BITS-1:0];
    end
  end

endmodule

`default_nettype wire

/* rtl/core/gtp_queue.sv */
`default_nettype none

module gtp_queue
  import gtp_pkg::*;
#(
  parameter int WIDTH = 116
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic [WIDTH-1:0] in_data,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic [WIDTH-1:0]      out_data
);

  logic [WIDTH-1:0]  entries [QUEUE_DEPTH];
  logic [QUEUE_AW:0] wr_ptr;
  logic [QUEUE_AW:0] rd_ptr;
  logic              full;
  logic              push;
  logic              pop;

  // Pointer compare with a wrap bit
  assign full = (wr_ptr[QUEUE_AW] != rd_ptr[QUEUE_AW]) &&
                (wr_ptr[QUEUE_AW-1:0] == rd_ptr[QUEUE_AW-1:0]);
  assign out_valid = (wr_ptr != rd_ptr);
  assign in_ready  = !full;
  assign push      = in_valid && !full;
  assign pop       = out_valid && out_ready;
  assign out_data  = entries[rd_ptr[QUEUE_AW-1:0]];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr[QUEUE_AW-1:0]] <= in_data;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/gtp_back.sv */
`default_nettype none

module gtp_back
  import gtp_pkg::*;
#(
  parameter int COORD_BITS = 12,
  parameter int COUNT_BITS = 16
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic [TOL_BITS-1:0] tol_min,
  input  wire logic q_valid,
  output logic      q_ready,
  input  wire op_t  q_op,
  input  wire logic [6*COORD_BITS+AREA_BITS+PERIM_BITS-1:0] q_data,
  output logic      m_axis_tvalid,
  input  wire logic m_axis_tready,
  // tuser: matched
  output logic      m_axis_tuser,
  // tdata: pred_cx, pred_cy, pred_bx, pred_by, box_height, box_width,
  //        frames_unseen, sightings, zero pad
  output logic [((4*PRED_BITS+2*COORD_BITS+2*REPORT_BITS+7)/8)*8-1:0] m_axis_tdata
);

  localparam int OUT_BITS  = 4*PRED_BITS + 2*COORD_BITS + 2*REPORT_BITS;
  localparam int OUT_W     = ((OUT_BITS + 7) / 8) * 8;
  localparam int VEL_BITS  = ((COORD_BITS > TOL_BITS) ? COORD_BITS : TOL_BITS) + 1;
  localparam int MAG_BITS  = VEL_BITS - 1;
  localparam int PROD_BITS = COUNT_BITS + MAG_BITS;
  localparam int TOL3_BITS = PROD_BITS + 2;
  localparam int KV_BITS   = COUNT_BITS + 1 + VEL_BITS;
  localparam int SUM_BITS  = KV_BITS + 1;
  localparam int CNT_W     = (COUNT_BITS > REPORT_BITS) ? COUNT_BITS : REPORT_BITS;

  localparam int CX_LSB = 0;
  localparam int CY_LSB = CX_LSB + COORD_BITS;
  localparam int AR_LSB = CY_LSB + COORD_BITS;
  localparam int PE_LSB = AR_LSB + AREA_BITS;
  localparam int BX_LSB = PE_LSB + PERIM_BITS;
  localparam int BY_LSB = BX_LSB + COORD_BITS;
  localparam int BH_LSB = BY_LSB + COORD_BITS;
  localparam int BW_LSB = BH_LSB + COORD_BITS;

  // Clamp a prediction to the signed output range
  function automatic logic [PRED_BITS-1:0] sat_pred(input logic signed [SUM_BITS-1:0] v);
    logic [PRED_BITS-1:0] r;
    if (v > $signed(SUM_BITS'(PRED_MAX))) begin
      r = PRED_BITS'(PRED_MAX);
    end else if (v < $signed(SUM_BITS'(PRED_MIN))) begin
      r = PRED_BITS'(PRED_MIN);
    end else begin
      r = v[PRED_BITS-1:0];
    end
    return r;
  endfunction

  // Clamp a counter to the report width
  function automatic logic [REPORT_BITS-1:0] sat_cnt(input logic [COUNT_BITS-1:0] c);
    logic [CNT_W-1:0] w;
    w = CNT_W'(c);
    return (w > CNT_W'({REPORT_BITS{1'b1}})) ? {REPORT_BITS{1'b1}} : w[REPORT_BITS-1:0];
  endfunction

  // Track state
  logic [COORD_BITS-1:0]      pos_x, pos_y;
  logic signed [VEL_BITS-1:0] vel_x, vel_y;
  logic [COUNT_BITS-1:0]      frame_age, last_seen, seen_count;
  logic [AREA_BITS-1:0]       ref_area;
  logic [PERIM_BITS-1:0]      ref_perimeter;
  logic [COORD_BITS-1:0]      box_left, box_top, box_h, box_w;

  logic [COORD_BITS-1:0]      pos_x_next, pos_y_next;
  logic signed [VEL_BITS-1:0] vel_x_next, vel_y_next;
  logic [COUNT_BITS-1:0]      frame_age_next, last_seen_next, seen_count_next;
  logic [AREA_BITS-1:0]       ref_area_next;
  logic [PERIM_BITS-1:0]      ref_perimeter_next;
  logic [COORD_BITS-1:0]      box_left_next, box_top_next, box_h_next, box_w_next;

  // Incoming fields
  logic [COORD_BITS-1:0] in_cx, in_cy, in_bx, in_by, in_bh, in_bw;
  logic [AREA_BITS-1:0]  in_area;
  logic [PERIM_BITS-1:0] in_perim;

  logic                  en;
  logic                  pop;
  logic [COUNT_BITS-1:0] unseen;
  logic [COUNT_BITS-1:0] age_inc, seen_inc;
  logic [COUNT_BITS-1:0] k_lead;
  logic [COORD_BITS-1:0] dx, dy;
  logic [MAG_BITS-1:0]   mag_x, mag_y;
  logic [AREA_BITS-1:0]  area_diff;
  logic [PERIM_BITS-1:0] perim_diff;

  // Stage 1: gate operands of the pre-command state
  logic                  s1_valid, s1_test;
  logic [COUNT_BITS-1:0] s1_u;
  logic [MAG_BITS-1:0]   s1_mag_x, s1_mag_y;
  logic [COORD_BITS-1:0] s1_dx, s1_dy;
  logic [AREA_BITS-1:0]  s1_area_diff, s1_area_ref;
  logic [PERIM_BITS-1:0] s1_perim_diff, s1_perim_ref;

  // Stage 2: gate products and post-command snapshot
  logic                       s2_valid, s2_shape_ok;
  logic [PROD_BITS-1:0]       s2_px, s2_py;
  logic [COORD_BITS-1:0]      s2_dx, s2_dy;
  logic [COUNT_BITS-1:0]      s2_k;
  logic signed [VEL_BITS-1:0] s2_vx, s2_vy;
  logic [COORD_BITS-1:0]      s2_pos_x, s2_pos_y, s2_left, s2_top, s2_h, s2_w;
  logic [REPORT_BITS-1:0]     s2_unseen, s2_seen;

  // Stage 3: match result and extrapolation products
  logic                       s3_valid, s3_matched;
  logic signed [KV_BITS-1:0]  s3_kvx, s3_kvy;
  logic [COORD_BITS-1:0]      s3_pos_x, s3_pos_y, s3_left, s3_top, s3_h, s3_w;
  logic [REPORT_BITS-1:0]     s3_unseen, s3_seen;

  logic [PROD_BITS-1:0]       px, py;
  logic                       area_ok, perim_ok;
  logic [TOL3_BITS-1:0]       tol3_x, tol3_y, tol_floor;
  logic                       x_ok, y_ok;
  logic signed [KV_BITS-1:0]  kvx, kvy;
  logic signed [SUM_BITS-1:0] sum_cx, sum_cy, sum_bx, sum_by;

  // The whole back pipeline moves together when the output can take data
  assign en      = !m_axis_tvalid || m_axis_tready;
  assign q_ready = en;
  assign pop     = en && q_valid;

  assign in_cx    = q_data[CX_LSB +: COORD_BITS];
  assign in_cy    = q_data[CY_LSB +: COORD_BITS];
  assign in_area  = q_data[AR_LSB +: AREA_BITS];
  assign in_perim = q_data[PE_LSB +: PERIM_BITS];
  assign in_bx    = q_data[BX_LSB +: COORD_BITS];
  assign in_by    = q_data[BY_LSB +: COORD_BITS];
  assign in_bh    = q_data[BH_LSB +: COORD_BITS];
  assign in_bw    = q_data[BW_LSB +: COORD_BITS];

  // Frames since last sighting, read from the live state. It is the
  // pre-command value for the queue head and the post-command value
  // for the item sitting in stage 1.
  assign unseen   = (last_seen > frame_age) ? '0 : frame_age - last_seen;
  assign age_inc  = (frame_age == {COUNT_BITS{1'b1}}) ? frame_age : frame_age + 1'b1;
  assign seen_inc = (seen_count == {COUNT_BITS{1'b1}}) ? seen_count : seen_count + 1'b1;
  assign k_lead   = (unseen <= COUNT_BITS'(1)) ? '0 : unseen - 1'b1;

  // Gate operands
  assign dx = (in_cx > pos_x) ? in_cx - pos_x : pos_x - in_cx;
  assign dy = (in_cy > pos_y) ? in_cy - pos_y : pos_y - in_cy;
  assign mag_x = vel_x[VEL_BITS-1] ? MAG_BITS'(-vel_x) : MAG_BITS'(vel_x);
  assign mag_y = vel_y[VEL_BITS-1] ? MAG_BITS'(-vel_y) : MAG_BITS'(vel_y);
  assign area_diff  = (in_area > ref_area) ? in_area - ref_area : ref_area - in_area;
  assign perim_diff = (in_perim > ref_perimeter) ? in_perim - ref_perimeter
                                                  : ref_perimeter - in_perim;

  // Command execution
  always_comb begin
    pos_x_next         = pos_x;
    pos_y_next         = pos_y;
    vel_x_next         = vel_x;
    vel_y_next         = vel_y;
    frame_age_next     = frame_age;
    last_seen_next     = last_seen;
    seen_count_next    = seen_count;
    ref_area_next      = ref_area;
    ref_perimeter_next = ref_perimeter;
    box_left_next      = box_left;
    box_top_next       = box_top;
    box_h_next         = box_h;
    box_w_next         = box_w;
    if (q_op.start || q_op.accept) begin
      pos_x_next         = in_cx;
      pos_y_next         = in_cy;
      ref_area_next      = in_area;
      ref_perimeter_next = in_perim;
      box_left_next      = in_bx;
      box_top_next       = in_by;
      box_h_next         = in_bh;
      box_w_next         = in_bw;
    end
    if (q_op.start) begin
      vel_x_next      = $signed(VEL_BITS'(tol_min));
      vel_y_next      = $signed(VEL_BITS'(tol_min));
      frame_age_next  = '0;
      last_seen_next  = '0;
      seen_count_next = '0;
    end
    if (q_op.accept) begin
      vel_x_next      = $signed(VEL_BITS'(in_cx)) - $signed(VEL_BITS'(pos_x));
      vel_y_next      = $signed(VEL_BITS'(in_cy)) - $signed(VEL_BITS'(pos_y));
      last_seen_next  = frame_age;
      frame_age_next  = age_inc;
      seen_count_next = seen_inc;
    end
    if (q_op.age) begin
      frame_age_next = age_inc;
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      pos_x         <= '0;
      pos_y         <= '0;
      vel_x         <= '0;
      vel_y         <= '0;
      frame_age     <= '0;
      last_seen     <= '0;
      seen_count    <= '0;
      ref_area      <= '0;
      ref_perimeter <= '0;
      box_left      <= '0;
      box_top       <= '0;
      box_h         <= '0;
      box_w         <= '0;
    end else if (pop) begin
      pos_x         <= pos_x_next;
      pos_y         <= pos_y_next;
      vel_x         <= vel_x_next;
      vel_y         <= vel_y_next;
      frame_age     <= frame_age_next;
      last_seen     <= last_seen_next;
      seen_count    <= seen_count_next;
      ref_area      <= ref_area_next;
      ref_perimeter <= ref_perimeter_next;
      box_left      <= box_left_next;
      box_top       <= box_top_next;
      box_h         <= box_h_next;
      box_w         <= box_w_next;
    end
  end

  // Stage 2 logic: tolerance products and shape compares
  assign px       = s1_u * s1_mag_x;
  assign py       = s1_u * s1_mag_y;
  assign area_ok  = {s1_area_diff, 2'b00} < {2'b00, s1_area_ref};
  assign perim_ok = {s1_perim_diff, 2'b00} < {2'b00, s1_perim_ref};

  // Stage 3 logic: centroid gate and extrapolation
  assign tol3_x    = TOL3_BITS'(s2_px) + TOL3_BITS'({s2_px, 1'b0});
  assign tol3_y    = TOL3_BITS'(s2_py) + TOL3_BITS'({s2_py, 1'b0});
  assign tol_floor = TOL3_BITS'(tol_min);
  assign x_ok = (TOL3_BITS'(s2_dx) < tol_floor) || (TOL3_BITS'(s2_dx) < tol3_x);
  assign y_ok = (TOL3_BITS'(s2_dy) < tol_floor) || (TOL3_BITS'(s2_dy) < tol3_y);
  assign kvx  = $signed({1'b0, s2_k}) * s2_vx;
  assign kvy  = $signed({1'b0, s2_k}) * s2_vy;

  // Output stage sums
  assign sum_cx = $signed(SUM_BITS'(s3_pos_x)) + $signed({s3_kvx[KV_BITS-1], s3_kvx});
  assign sum_cy = $signed(SUM_BITS'(s3_pos_y)) + $signed({s3_kvy[KV_BITS-1], s3_kvy});
  assign sum_bx = $signed(SUM_BITS'(s3_left)) + $signed({s3_kvx[KV_BITS-1], s3_kvx});
  assign sum_by = $signed(SUM_BITS'(s3_top)) + $signed({s3_kvy[KV_BITS-1], s3_kvy});

  // Pipeline valid chain
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid      <= 1'b0;
      s2_valid      <= 1'b0;
      s3_valid      <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else if (en) begin
      s1_valid      <= q_valid;
      s2_valid      <= s1_valid;
      s3_valid      <= s2_valid;
      m_axis_tvalid <= s3_valid;
    end
  end

  // Pipeline payload
  always_ff @(posedge clk) begin
    if (en) begin
      s1_test       <= q_op.test;
      s1_u          <= unseen;
      s1_mag_x      <= mag_x;
      s1_mag_y      <= mag_y;
      s1_dx         <= dx;
      s1_dy         <= dy;
      s1_area_diff  <= area_diff;
      s1_area_ref   <= ref_area;
      s1_perim_diff <= perim_diff;
      s1_perim_ref  <= ref_perimeter;

      // state registers hold the result of the stage 1 command here
      s2_shape_ok <= s1_test && area_ok && perim_ok;
      s2_px       <= px;
      s2_py       <= py;
      s2_dx       <= s1_dx;
      s2_dy       <= s1_dy;
      s2_k        <= k_lead;
      s2_vx       <= vel_x;
      s2_vy       <= vel_y;
      s2_pos_x    <= pos_x;
      s2_pos_y    <= pos_y;
      s2_left     <= box_left;
      s2_top      <= box_top;
      s2_h        <= box_h;
      s2_w        <= box_w;
      s2_unseen   <= sat_cnt(unseen);
      s2_seen     <= sat_cnt(seen_count);

      s3_matched <= s2_shape_ok && x_ok && y_ok;
      s3_kvx     <= kvx;
      s3_kvy     <= kvy;
      s3_pos_x   <= s2_pos_x;
      s3_pos_y   <= s2_pos_y;
      s3_left    <= s2_left;
      s3_top     <= s2_top;
      s3_h       <= s2_h;
      s3_w       <= s2_w;
      s3_unseen  <= s2_unseen;
      s3_seen    <= s2_seen;

      m_axis_tuser <= s3_matched;
      m_axis_tdata <= OUT_W'({s3_seen, s3_unseen, s3_w, s3_h,
                              sat_pred(sum_by), sat_pred(sum_bx),
                              sat_pred(sum_cy), sat_pred(sum_cx)});
    end
  end

endmodule

`default_nettype wire

/* rtl/core/gated_track_predictor.sv */
// Gated constant-velocity track predictor.
// Path from input transaction to result valid: input register, command queue,
// execute/gate stage, product stage, compare stage, output register.
// Throughput: one command per cycle when not stalled, set by the state update loop.
// Reset (rst, synchronous, active high) clears the track state, queue and valids
// and loads tolerance_min with 20.
`default_nettype none

module gated_track_predictor
  import gtp_pkg::*;
#(
  parameter int COORD_BITS = 12,
  parameter int COUNT_BITS = 16
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic cfg_we,
  input  wire logic [TOL_BITS-1:0] cfg_wdata,
  input  wire logic s_axis_tvalid,
  output logic      s_axis_tready,
  // tuser: cmd
  input  wire logic [CMD_BITS-1:0] s_axis_tuser,
  // tdata: cx, cy, obj_area, obj_perimeter, bx, by, bh, bw, zero pad
  input  wire logic [((6*COORD_BITS+AREA_BITS+PERIM_BITS+7)/8)*8-1:0] s_axis_tdata,
  output logic      m_axis_tvalid,
  input  wire logic m_axis_tready,
  // tuser: matched
  output logic      m_axis_tuser,
  // tdata: pred_cx, pred_cy, pred_bx, pred_by, box_height, box_width,
  //        frames_unseen, sightings, zero pad
  output logic [((4*PRED_BITS+2*COORD_BITS+2*REPORT_BITS+7)/8)*8-1:0] m_axis_tdata
);

  localparam int IN_BITS = 6*COORD_BITS + AREA_BITS + PERIM_BITS;
  localparam int Q_BITS  = OP_BITS + IN_BITS;

  logic [TOL_BITS-1:0] tolerance_min;

  logic               item_valid, item_ready;
  op_t                item_op;
  logic [IN_BITS-1:0] item_data;

  logic               q_valid, q_ready;
  logic [Q_BITS-1:0]  q_word;
  op_t                q_op;
  logic [IN_BITS-1:0] q_data;

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      tolerance_min <= TOL_RESET;
    end else if (cfg_we) begin
      tolerance_min <= cfg_wdata;
    end
  end

  gtp_front #(
    .COORD_BITS(COORD_BITS)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tuser (s_axis_tuser),
    .s_axis_tdata (s_axis_tdata),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item_op      (item_op),
    .item_data    (item_data)
  );

  gtp_queue #(
    .WIDTH(Q_BITS)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .in_valid (item_valid),
    .in_ready (item_ready),
    .in_data  ({item_op, item_data}),
    .out_valid(q_valid),
    .out_ready(q_ready),
    .out_data (q_word)
  );

  assign q_op   = op_t'(q_word[Q_BITS-1 -: OP_BITS]);
  assign q_data = q_word[IN_BITS-1:0];

  gtp_back #(
    .COORD_BITS(COORD_BITS),
    .COUNT_BITS(COUNT_BITS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .tol_min      (tolerance_min),
    .q_valid      (q_valid),
    .q_ready      (q_ready),
    .q_op         (q_op),
    .q_data       (q_data),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tdata (m_axis_tdata)
  );

endmodule

`default_nettype wire
